/* rtl/trrs_pkg.sv */
// Shared constants, command and status codes, and the control type of the task scheduler.
package trrs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int KEY_BITS  = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int PC_W      = 32;
  localparam int ID_W      = 32;
  localparam int SW_W      = 32;
  localparam int KEY_IN_W  = 16;

  localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SWITCH  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SAVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SPAWN   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE_RUN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic cmd_load;
    logic exec;
    logic out_load;
  } trrs_ctl_t;

endpackage

/* rtl/task_table_round_robin_scheduler.sv */
// Top level of the round-robin task table scheduler.
//
//  channel | dir | handshake          | tuser        | tdata
//  in_     | in  | in_tvalid/tready   | cmd[2:0]     | task_index, wait_key, pc_value
//  out_    | out | out_tvalid/tready  | status[1:0]  | index, id, pc, runnable, switches
//
// Each request passes through S_EXEC, which updates the task table, then S_LOAD,
// which counts runnable tasks into the output register. The next request is taken
// in S_LOAD when the output register is free or being drained.
// A stalled result holds the block after the table update; reset restores
// the single running task 0 with the next id at 1.
module task_table_round_robin_scheduler import trrs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // cmd
  input  logic [55:0]  in_tdata,   // task_index[3:0], wait_key[19:4], pc_value[51:20]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [111:0] out_tdata   // result_index[3:0], result_id[35:4], result_pc[67:36],
                                   // runnable_total[72:68], switch_total[104:73]
);

  trrs_ctl_t         ctl;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  result_index;
  logic [ID_W-1:0]   result_id;
  logic [PC_W-1:0]   result_pc;
  logic [CNT_W-1:0]  runnable_total;
  logic [SW_W-1:0]   switch_total;

  trrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  trrs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cmd            (in_tuser),
    .task_index     (in_tdata[3:0]),
    .wait_key       (in_tdata[19:4]),
    .pc_value       (in_tdata[51:20]),
    .status         (status),
    .result_index   (result_index),
    .result_id      (result_id),
    .result_pc      (result_pc),
    .runnable_total (runnable_total),
    .switch_total   (switch_total)
  );

  assign out_tuser = status;
  assign out_tdata = {7'd0, switch_total, runnable_total, result_pc, result_id, result_index};

endmodule

/* rtl/trrs_ctrl.sv */
// Sequencer for the task scheduler: request handshake and output register control.
module trrs_ctrl import trrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output trrs_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_LOAD) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign ctl.cmd_load = accept;
  assign ctl.exec     = (state_r == S_EXEC);
  assign ctl.out_load = (state_r == S_LOAD) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/trrs_dp.sv */
// Datapath of the task scheduler: task table, round-robin pick, counters and result register.
module trrs_dp import trrs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  trrs_ctl_t           ctl,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [IDX_W-1:0]    task_index,
  input  logic [KEY_IN_W-1:0] wait_key,
  input  logic [PC_W-1:0]     pc_value,
  output logic [STAT_W-1:0]   status,
  output logic [IDX_W-1:0]    result_index,
  output logic [ID_W-1:0]     result_id,
  output logic [PC_W-1:0]     result_pc,
  output logic [CNT_W-1:0]    runnable_total,
  output logic [SW_W-1:0]     switch_total
);

  // latched request
  logic [CMD_W-1:0]    cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic [KEY_BITS-1:0] key_r;
  logic [PC_W-1:0]     pc_r;

  // task table
  logic [MAX_TASKS-1:0] active_r, active_nxt;
  logic [MAX_TASKS-1:0] fin_r, fin_nxt;
  logic [MAX_TASKS-1:0] blk_r, blk_nxt;
  logic [KEY_BITS-1:0]  keys_r [MAX_TASKS];
  logic [KEY_BITS-1:0]  keys_nxt [MAX_TASKS];
  logic [PC_W-1:0]      pcs_r [MAX_TASKS];
  logic [PC_W-1:0]      pcs_nxt [MAX_TASKS];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic [SW_W-1:0]      sw_cnt_r, sw_cnt_nxt;

  // per-request result
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_index_r, res_index_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [PC_W-1:0]   res_pc_r, res_pc_nxt;

  // output register
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [ID_W-1:0]   out_id_r;
  logic [PC_W-1:0]   out_pc_r;
  logic [CNT_W-1:0]  out_run_r;
  logic [SW_W-1:0]   out_sw_r;

  logic [MAX_TASKS-1:0]   run_vec;
  logic [2*MAX_TASKS-1:0] dbl;
  logic [MAX_TASKS-1:0]   rot;
  logic [IDX_W-1:0]       start;
  logic [IDX_W-1:0]       off;
  logic [IDX_W-1:0]       pick;
  logic                   found;
  logic                   idx_ok;
  logic                   full;
  logic [IDX_W-1:0]       new_slot;
  logic [CNT_W-1:0]       run_cnt;

  assign run_vec  = active_r & ~fin_r & ~blk_r;
  assign start    = cur_r + 1'b1;
  assign dbl      = {run_vec, run_vec} >> start;
  assign rot      = dbl[MAX_TASKS-1:0];
  assign found    = |rot;
  assign pick     = start + off;
  assign idx_ok   = {1'b0, idx_r} < count_r;
  assign full     = count_r == CNT_W'(MAX_TASKS);
  assign new_slot = count_r[IDX_W-1:0];

  // first runnable slot after the current one, wrapping
  always_comb begin
    off = '0;
    for (int j = MAX_TASKS - 1; j >= 0; j--) begin
      if (rot[j]) off = IDX_W'(j);
    end
  end

  always_comb begin
    run_cnt = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      run_cnt = run_cnt + CNT_W'(run_vec[i]);
    end
  end

  always_comb begin
    active_nxt     = active_r;
    fin_nxt        = fin_r;
    blk_nxt        = blk_r;
    keys_nxt       = keys_r;
    pcs_nxt        = pcs_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    next_id_nxt    = next_id_r;
    sw_cnt_nxt     = sw_cnt_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_id_nxt     = res_id_r;
    res_pc_nxt     = res_pc_r;
    if (ctl.exec) begin
      res_status_nxt = ST_OK;
      res_index_nxt  = '0;
      res_id_nxt     = '0;
      res_pc_nxt     = '0;
      case (cmd_r)
        CMD_NEXT: begin
          if (found) begin
            res_index_nxt = pick;
            if (pick != cur_r) sw_cnt_nxt = sw_cnt_r + 1'b1;
          end else begin
            res_status_nxt = ST_NONE_RUN;
          end
        end
        CMD_SWITCH: begin
          if (idx_ok) begin
            cur_nxt       = idx_r;
            res_index_nxt = idx_r;
            res_pc_nxt    = pcs_r[idx_r];
          end else begin
            res_status_nxt = ST_BAD_INDEX;
          end
        end
        CMD_SAVE: begin
          if (idx_ok) pcs_nxt[idx_r] = pc_r;
          else res_status_nxt = ST_BAD_INDEX;
        end
        CMD_SPAWN: begin
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            active_nxt[new_slot] = 1'b1;
            fin_nxt[new_slot]    = 1'b0;
            blk_nxt[new_slot]    = 1'b0;
            keys_nxt[new_slot]   = '0;
            pcs_nxt[new_slot]    = pc_r;
            res_index_nxt        = new_slot;
            res_id_nxt           = next_id_r;
            next_id_nxt          = next_id_r + 1'b1;
            count_nxt            = count_r + 1'b1;
          end
        end
        CMD_BLOCK: begin
          if (idx_ok) begin
            blk_nxt[idx_r]  = 1'b1;
            keys_nxt[idx_r] = key_r;
          end else begin
            res_status_nxt = ST_BAD_INDEX;
          end
        end
        CMD_FINISH: begin
          if (idx_ok) fin_nxt[idx_r] = 1'b1;
          else res_status_nxt = ST_BAD_INDEX;
        end
        CMD_UNBLOCK: begin
          // only slots below the task count are ever active
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (active_r[i] && blk_r[i] && (key_r == '0 || keys_r[i] == key_r)) begin
              blk_nxt[i]  = 1'b0;
              keys_nxt[i] = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd_load) begin
      cmd_r <= cmd;
      idx_r <= task_index;
      key_r <= KEY_BITS'(wait_key);
      pc_r  <= pc_value;
    end
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_id_r     <= res_id_nxt;
    res_pc_r     <= res_pc_nxt;
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_id_r     <= res_id_r;
      out_pc_r     <= res_pc_r;
      out_run_r    <= run_cnt;
      out_sw_r     <= sw_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
      fin_r     <= '0;
      blk_r     <= '0;
      count_r   <= CNT_W'(1);
      cur_r     <= '0;
      next_id_r <= ID_W'(1);
      sw_cnt_r  <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        keys_r[i] <= '0;
        pcs_r[i]  <= '0;
      end
    end else begin
      active_r  <= active_nxt;
      fin_r     <= fin_nxt;
      blk_r     <= blk_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      next_id_r <= next_id_nxt;
      sw_cnt_r  <= sw_cnt_nxt;
      keys_r    <= keys_nxt;
      pcs_r     <= pcs_nxt;
    end
  end

  assign status         = out_status_r;
  assign result_index   = out_index_r;
  assign result_id      = out_id_r;
  assign result_pc      = out_pc_r;
  assign runnable_total = out_run_r;
  assign switch_total   = out_sw_r;

endmodule
